// ===== rtl/crl_pkg.sv =====
// Shared constants, codes and types of the closed-loop Catmull-Rom point evaluator.
`default_nettype none

package crl_pkg;

    // Field widths fixed by the interface
    localparam int COORD_BITS      = 32;   // signed Q16.16 coordinates
    localparam int PARAM_FRAC_BITS = 16;   // unsigned Q0.16 curve parameter
    localparam int INDEX_BITS      = 6;    // load slot field
    localparam int COUNT_BITS      = 7;    // point count register

    localparam int MAX_POINTS = 64;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd4;

    // Four control points feed every segment
    localparam int TAPS = 4;

    // Doubled basis weights fit well inside F+6 signed bits
    localparam int WEIGHT_BITS = PARAM_FRAC_BITS + 6;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } t_kind;

    // Local parameter and its square, handed from the address stage to the blend pipe
    typedef struct packed {
        logic [PARAM_FRAC_BITS-1:0] t;
        logic [PARAM_FRAC_BITS-1:0] t2;
    } t_frac;

endpackage

`default_nettype wire

// ===== rtl/crl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module crl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/crl_front.sv =====
// Input and segment stages: parameter scaling, wraparound indices, t squared, table writes.
`default_nettype none

module crl_front #(
    parameter int MAX_POINTS = crl_pkg::MAX_POINTS,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int CW = crl_pkg::COUNT_BITS,
    localparam int F  = crl_pkg::PARAM_FRAC_BITS,
    localparam int C  = crl_pkg::COORD_BITS,
    localparam int IW = crl_pkg::INDEX_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item input
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_kind,
    input  wire logic [IW-1:0]         i_point_index,
    input  wire logic [3*C-1:0]        i_point,
    input  wire logic [F-1:0]          i_global_t,
    input  wire logic [CW-1:0]         i_count,
    // table write
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [3*C-1:0]             o_wdata,
    // evaluate item toward the blend pipe
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [crl_pkg::TAPS-1:0][AW-1:0] o_raddr,
    output crl_pkg::t_frac             o_frac
);

    logic                 r_s0_valid;
    crl_pkg::t_kind       r_s0_kind;
    logic [IW-1:0]        r_s0_slot;
    logic [3*C-1:0]       r_s0_pt;
    logic [F-1:0]         r_s0_gt;

    logic                 r_s1_valid;
    crl_pkg::t_kind       r_s1_kind;
    logic [IW-1:0]        r_s1_slot;
    logic [3*C-1:0]       r_s1_pt;
    logic [F+CW-1:0]      r_s1_prod;
    logic [CW-1:0]        r_s1_n;

    logic                 s0_rdy;
    logic                 s1_rdy;
    logic [CW-1:0]        cnt_clamped;
    logic [CW-1:0]        seg_raw;
    logic [CW-1:0]        seg;
    logic [CW-1:0]        last;
    logic [CW-1:0]        ix0;
    logic [CW-1:0]        ix2;
    logic [CW-1:0]        ix3;
    logic [F-1:0]         t;
    logic [2*F-1:0]       tsq;

    // zero counts as one, large counts saturate at the table depth
    always_comb begin
        cnt_clamped = i_count;
        if (i_count == '0) begin
            cnt_clamped = CW'(1);
        end else if (32'(i_count) > 32'(MAX_POINTS)) begin
            cnt_clamped = CW'(MAX_POINTS);
        end
    end

    // loads leave at stage 1 without waiting on the blend pipe
    assign s1_rdy  = !r_s1_valid || (r_s1_kind == crl_pkg::KIND_LOAD) || i_ready;
    assign s0_rdy  = !r_s0_valid || s1_rdy;
    assign o_ready = s0_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s0_rdy) begin
                r_s0_valid <= i_valid;
            end
            if (s1_rdy) begin
                r_s1_valid <= r_s0_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_rdy) begin
            r_s0_kind <= crl_pkg::t_kind'(i_kind);
            r_s0_slot <= i_point_index;
            r_s0_pt   <= i_point;
            r_s0_gt   <= i_global_t;
        end
        if (s1_rdy) begin
            r_s1_kind <= r_s0_kind;
            r_s1_slot <= r_s0_slot;
            r_s1_pt   <= r_s0_pt;
            r_s1_prod <= {{CW{1'b0}}, r_s0_gt} * {{F{1'b0}}, cnt_clamped};
            r_s1_n    <= cnt_clamped;
        end
    end

    // segment, wrapped neighbors and t^2
    always_comb begin
        seg_raw = r_s1_prod[F+CW-1:F];
        last    = r_s1_n - CW'(1);
        seg     = (seg_raw >= r_s1_n) ? last : seg_raw;
        ix0     = (seg == '0)   ? last : seg - CW'(1);
        ix2     = (seg == last) ? '0   : seg + CW'(1);
        ix3     = (ix2 == last) ? '0   : ix2 + CW'(1);
        t       = r_s1_prod[F-1:0];
        tsq     = {{F{1'b0}}, t} * {{F{1'b0}}, t};
    end

    assign o_raddr   = {AW'(ix3), AW'(ix2), AW'(seg), AW'(ix0)};
    assign o_frac.t  = t;
    assign o_frac.t2 = tsq[2*F-1:F];
    assign o_valid   = r_s1_valid && (r_s1_kind == crl_pkg::KIND_EVAL);

    assign o_we    = r_s1_valid && (r_s1_kind == crl_pkg::KIND_LOAD)
                     && (32'(r_s1_slot) < 32'(MAX_POINTS));
    assign o_waddr = AW'(r_s1_slot);
    assign o_wdata = r_s1_pt;

endmodule

`default_nettype wire

// ===== rtl/crl_blend.sv =====
// Blend pipe: t^3, basis weights, weight-by-point products, sums, rounding and saturation.
`default_nettype none

module crl_blend #(
    localparam int F   = crl_pkg::PARAM_FRAC_BITS,
    localparam int C   = crl_pkg::COORD_BITS,
    localparam int WB  = crl_pkg::WEIGHT_BITS,
    localparam int PW  = WB + C,
    localparam int ACC = PW + 2,
    localparam int NT  = crl_pkg::TAPS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire crl_pkg::t_frac             i_frac,
    input  wire logic [NT-1:0][3*C-1:0]     i_pts,    // registered RAM data, stage 2
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [C-1:0]                    o_pos_x,
    output logic [C-1:0]                    o_pos_y,
    output logic [C-1:0]                    o_pos_z,
    output logic [C-1:0]                    o_tangent_x,
    output logic [C-1:0]                    o_tangent_y,
    output logic [C-1:0]                    o_tangent_z
);

    localparam logic signed [WB-1:0]  ONE    = WB'(64'd1 << F);
    localparam logic signed [ACC-1:0] HALF   = ACC'(64'd1 << F);
    localparam logic signed [ACC-1:0] SAT_HI = {{(ACC-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [ACC-1:0] SAT_LO = {{(ACC-C+1){1'b1}}, {(C-1){1'b0}}};

    // stage valid bits: [0] is stage 2 ... [5] is stage 7 (output)
    logic [5:0]               r_vld;
    logic [5:0]               rdy;

    logic [F-1:0]             r_s2_t;
    logic [F-1:0]             r_s2_t2;

    logic [F-1:0]             r_s3_t;
    logic [F-1:0]             r_s3_t2;
    logic [F-1:0]             r_s3_t3;
    logic signed [C-1:0]      r_s3_pt [NT][3];

    logic signed [WB-1:0]     r_s4_wp [NT];
    logic signed [WB-1:0]     r_s4_wd [NT];
    logic signed [C-1:0]      r_s4_pt [NT][3];

    logic signed [PW-1:0]     r_s5_pp [3][NT];
    logic signed [PW-1:0]     r_s5_pd [3][NT];

    logic signed [ACC-1:0]    r_s6_sp [3];
    logic signed [ACC-1:0]    r_s6_sd [3];

    logic [C-1:0]             r_s7_pos [3];
    logic [C-1:0]             r_s7_tan [3];

    logic [2*F-1:0]           t3sq;
    logic signed [WB-1:0]     wt;
    logic signed [WB-1:0]     wt2;
    logic signed [WB-1:0]     wt3;
    logic signed [WB-1:0]     w_pos [NT];
    logic signed [WB-1:0]     w_der [NT];

    function automatic logic signed [WB-1:0] to_w(input logic [F-1:0] v);
        to_w = signed'({{(WB-F){1'b0}}, v});
    endfunction

    function automatic logic signed [ACC-1:0] widen(input logic signed [PW-1:0] v);
        widen = {{(ACC-PW){v[PW-1]}}, v};
    endfunction

    // round half up, drop F+1 fraction bits, clamp to the coordinate range
    function automatic logic [C-1:0] finish(input logic signed [ACC-1:0] a);
        logic signed [ACC-1:0] r;
        r = (a + HALF) >>> (F + 1);
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        finish = r[C-1:0];
    endfunction

    // ready ripples back from the output register
    always_comb begin
        rdy[5] = !r_vld[5] || i_ready;
        for (int k = 4; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < 6; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 2 -> 3: t^3
    assign t3sq = {{F{1'b0}}, r_s2_t2} * {{F{1'b0}}, r_s2_t};

    // stage 3 -> 4: doubled basis weights
    always_comb begin
        wt  = to_w(r_s3_t);
        wt2 = to_w(r_s3_t2);
        wt3 = to_w(r_s3_t3);
        w_pos[0] = (wt2 <<< 1) - wt3 - wt;
        w_pos[1] = (wt3 <<< 1) + wt3 - (wt2 <<< 2) - wt2 + (ONE <<< 1);
        w_pos[2] = (wt2 <<< 2) + wt - (wt3 <<< 1) - wt3;
        w_pos[3] = wt3 - wt2;
        w_der[0] = (wt <<< 2) - (wt2 <<< 1) - wt2 - ONE;
        w_der[1] = (wt2 <<< 3) + wt2 - (wt <<< 3) - (wt <<< 1);
        w_der[2] = (wt <<< 3) + ONE - (wt2 <<< 3) - wt2;
        w_der[3] = (wt2 <<< 1) + wt2 - (wt <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s2_t  <= i_frac.t;
            r_s2_t2 <= i_frac.t2;
        end
        if (rdy[1]) begin
            r_s3_t  <= r_s2_t;
            r_s3_t2 <= r_s2_t2;
            r_s3_t3 <= t3sq[2*F-1:F];
            for (int k = 0; k < NT; k++) begin
                r_s3_pt[k][0] <= signed'(i_pts[k][3*C-1:2*C]);
                r_s3_pt[k][1] <= signed'(i_pts[k][2*C-1:C]);
                r_s3_pt[k][2] <= signed'(i_pts[k][C-1:0]);
            end
        end
        if (rdy[2]) begin
            for (int k = 0; k < NT; k++) begin
                r_s4_wp[k] <= w_pos[k];
                r_s4_wd[k] <= w_der[k];
                for (int c = 0; c < 3; c++) begin
                    r_s4_pt[k][c] <= r_s3_pt[k][c];
                end
            end
        end
        if (rdy[3]) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < NT; k++) begin
                    r_s5_pp[c][k] <= PW'(r_s4_wp[k]) * PW'(r_s4_pt[k][c]);
                    r_s5_pd[c][k] <= PW'(r_s4_wd[k]) * PW'(r_s4_pt[k][c]);
                end
            end
        end
        if (rdy[4]) begin
            for (int c = 0; c < 3; c++) begin
                r_s6_sp[c] <= widen(r_s5_pp[c][0]) + widen(r_s5_pp[c][1])
                            + widen(r_s5_pp[c][2]) + widen(r_s5_pp[c][3]);
                r_s6_sd[c] <= widen(r_s5_pd[c][0]) + widen(r_s5_pd[c][1])
                            + widen(r_s5_pd[c][2]) + widen(r_s5_pd[c][3]);
            end
        end
        if (rdy[5]) begin
            for (int c = 0; c < 3; c++) begin
                r_s7_pos[c] <= finish(r_s6_sp[c]);
                r_s7_tan[c] <= finish(r_s6_sd[c]);
            end
        end
    end

    assign o_pos_x     = r_s7_pos[0];
    assign o_pos_y     = r_s7_pos[1];
    assign o_pos_z     = r_s7_pos[2];
    assign o_tangent_x = r_s7_tan[0];
    assign o_tangent_y = r_s7_tan[1];
    assign o_tangent_z = r_s7_tan[2];

endmodule

`default_nettype wire

// ===== rtl/catmull_rom_loop_point.sv =====
// Top level of the closed-loop Catmull-Rom point evaluator.
// Input channel (i_valid / o_ready) carries two kinds of item. A load item
// (i_kind = 0) writes i_point_x/y/z into table slot i_point_index; slots at
// or above MAX_POINTS are dropped. A load gives no result. An evaluate item
// (i_kind = 1) carries i_global_t in [0,1) and returns one result on the
// output channel (o_valid / i_ready): position and tangent w.r.t. local t,
// Q16.16, saturated.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the point
// count; change it only while no item is in flight. Zero acts as one, counts
// above MAX_POINTS act as MAX_POINTS.
// Pipeline:
//   One item per cycle is taken while the output is not stalled. The eight
//   register stages are: input, scaling multiply, index/t^2 with the table
//   read, t^3, weights, products, sums, round/saturate. Four table copies,
//   one per tap, give all points at once.
// Reset: clears all stage valid bits and sets the count to 4; the table
//   contents stay undefined until loaded.
// Stall: when i_ready is low, stages fill up behind the held result; o_ready
//   drops only once the pipe is full, and no item is lost or repeated.
`default_nettype none

module catmull_rom_loop_point #(
    parameter int MAX_POINTS = crl_pkg::MAX_POINTS,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int C  = crl_pkg::COORD_BITS,
    localparam int F  = crl_pkg::PARAM_FRAC_BITS,
    localparam int CW = crl_pkg::COUNT_BITS,
    localparam int IW = crl_pkg::INDEX_BITS,
    localparam int NT = crl_pkg::TAPS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // config write
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [CW-1:0] i_cfg_data,
    // items in
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_kind,
    input  wire logic [IW-1:0] i_point_index,
    input  wire logic [C-1:0]  i_point_x,
    input  wire logic [C-1:0]  i_point_y,
    input  wire logic [C-1:0]  i_point_z,
    input  wire logic [F-1:0]  i_global_t,
    // results out
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [C-1:0]       o_pos_x,
    output logic [C-1:0]       o_pos_y,
    output logic [C-1:0]       o_pos_z,
    output logic [C-1:0]       o_tangent_x,
    output logic [C-1:0]       o_tangent_y,
    output logic [C-1:0]       o_tangent_z
);

    logic [CW-1:0]             r_point_count;

    logic                      tab_we;
    logic [AW-1:0]             tab_waddr;
    logic [3*C-1:0]            tab_wdata;
    logic [NT-1:0][AW-1:0]     tab_raddr;
    logic [NT-1:0][3*C-1:0]    tab_rdata;
    logic                      tab_re;

    logic                      ev_valid;
    logic                      ev_ready;
    crl_pkg::t_frac            ev_frac;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= crl_pkg::COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
        end
    end

    crl_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_point_index (i_point_index),
        .i_point       ({i_point_x, i_point_y, i_point_z}),
        .i_global_t    (i_global_t),
        .i_count       (r_point_count),
        .o_we          (tab_we),
        .o_waddr       (tab_waddr),
        .o_wdata       (tab_wdata),
        .o_valid       (ev_valid),
        .i_ready       (ev_ready),
        .o_raddr       (tab_raddr),
        .o_frac        (ev_frac)
    );

    // read data lands in the blend pipe's first stage together with t, t^2
    assign tab_re = ev_valid && ev_ready;

    for (genvar g = 0; g < NT; g++) begin : g_tab
        crl_ram #(
            .WIDTH (3 * C),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (tab_we),
            .i_waddr (tab_waddr),
            .i_wdata (tab_wdata),
            .i_re    (tab_re),
            .i_raddr (tab_raddr[g]),
            .o_rdata (tab_rdata[g])
        );
    end

    crl_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (ev_valid),
        .o_ready     (ev_ready),
        .i_frac      (ev_frac),
        .i_pts       (tab_rdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_tangent_x (o_tangent_x),
        .o_tangent_y (o_tangent_y),
        .o_tangent_z (o_tangent_z)
    );

endmodule

`default_nettype wire

// ===== rtl/crl_checker.sv =====
// Port-level assertions for the Catmull-Rom point evaluator, bound to the top level.
`default_nettype none

module crl_checker #(
    localparam int C = crl_pkg::COORD_BITS
) (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_valid,
    input wire logic         o_ready,
    input wire logic         o_valid,
    input wire logic         i_ready,
    input wire logic [C-1:0] o_pos_x,
    input wire logic [C-1:0] o_pos_y,
    input wire logic [C-1:0] o_pos_z,
    input wire logic [C-1:0] o_tangent_x,
    input wire logic [C-1:0] o_tangent_y,
    input wire logic [C-1:0] o_tangent_z
);

    logic idle;

    // sink ready and nothing new taken
    assign idle = i_ready && !(i_valid && o_ready);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_pos_z) && $stable(o_tangent_x) && $stable(o_tangent_y)
            && $stable(o_tangent_z))
        else $error("result changed while stalled");

    // reset empties the output stage
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // an empty or draining output stage never blocks the input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input blocked while output side can move");

    // once the sink stays ready and nothing new is taken, every stage drains and o_valid falls
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idle ##1 idle ##1 idle ##1 idle ##1 idle ##1 idle ##1 idle ##1 idle ##1 idle
            |-> !o_valid)
        else $error("result appeared with no item in flight");

endmodule

bind catmull_rom_loop_point crl_checker u_crl_checker (.*);

`default_nettype wire

// ===== test/catmull_rom_loop_point_tb.sv =====
// Testbench for the closed-loop Catmull-Rom evaluator: scripted then random items vs. a predictor.
`timescale 1ns / 1ps

module catmull_rom_loop_point_tb;

    localparam int C          = crl_pkg::COORD_BITS;
    localparam int F          = crl_pkg::PARAM_FRAC_BITS;
    localparam int CW         = crl_pkg::COUNT_BITS;
    localparam int IW         = crl_pkg::INDEX_BITS;
    localparam int MAX_POINTS = crl_pkg::MAX_POINTS;
    localparam int TAPS       = crl_pkg::TAPS;

    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 12;    // pipe depth plus margin for loads in flight
    localparam int STALL_LIMIT    = 2000;  // cycles with no handshake at all
    localparam int RANDOM_ITEMS   = 1800;
    localparam int SQUEEZE_AT     = 300;   // random item that triggers the long hold-off
    localparam int SQUEEZE_CYCLES = 120;
    localparam int CALM_FROM      = 700;   // random items sent with no idling on either side
    localparam int CALM_TO        = 1000;
    localparam int REPORT_CAP     = 50;

    localparam longint COORD_MAX = (longint'(1) <<< (C - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // One result: position then tangent, pos_x in the top word
    typedef struct packed {
        logic [C-1:0] pos_x;
        logic [C-1:0] pos_y;
        logic [C-1:0] pos_z;
        logic [C-1:0] tan_x;
        logic [C-1:0] tan_y;
        logic [C-1:0] tan_z;
    } t_curve_pt;

    typedef struct {
        crl_pkg::t_kind kind;
        logic [IW-1:0]  slot;
        logic [C-1:0]   x;
        logic [C-1:0]   y;
        logic [C-1:0]   z;
        logic [F-1:0]   gt;
    } t_knot_item;

    typedef enum { ROW_ITEM, ROW_COUNT } t_row_op;

    typedef struct {
        t_row_op       op;
        t_knot_item    item;
        logic [CW-1:0] count;
        bit            typed;   // want holds a hand-computed result
        t_curve_pt     want;
    } t_script_row;

    // Clock, reset and DUT ports; every input starts at a known value
    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [CW-1:0] i_cfg_data = '0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic          i_kind = 1'b0;
    logic [IW-1:0] i_point_index = '0;
    logic [C-1:0]  i_point_x = '0;
    logic [C-1:0]  i_point_y = '0;
    logic [C-1:0]  i_point_z = '0;
    logic [F-1:0]  i_global_t = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [C-1:0]  o_pos_x;
    logic [C-1:0]  o_pos_y;
    logic [C-1:0]  o_pos_z;
    logic [C-1:0]  o_tangent_x;
    logic [C-1:0]  o_tangent_y;
    logic [C-1:0]  o_tangent_z;

    // Shadow of the block: point table, which slots hold data, and the count register
    longint                knot_x [MAX_POINTS];
    longint                knot_y [MAX_POINTS];
    longint                knot_z [MAX_POINTS];
    logic [MAX_POINTS-1:0] knot_loaded = '0;
    logic [CW-1:0]         loop_count = crl_pkg::COUNT_RESET;

    t_curve_pt   pending_pts [$];   // results owed by the DUT, oldest first
    t_script_row script [$];
    int          mismatches = 0;
    logic        squeeze_req = 1'b0;
    logic        calm = 1'b0;
    string       field_name [6] = '{"pos_x", "pos_y", "pos_z",
                                    "tangent_x", "tangent_y", "tangent_z"};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    catmull_rom_loop_point dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_global_t    (i_global_t),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_tangent_x   (o_tangent_x),
        .o_tangent_y   (o_tangent_y),
        .o_tangent_z   (o_tangent_z)
    );

    task automatic report_mismatch(string msg);
        if (mismatches < REPORT_CAP) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Count as the block uses it: zero acts as one, large values clamp to the table size
    function automatic int unsigned loop_points();
        if (loop_count == 0) return 1;
        if (loop_count > MAX_POINTS) return MAX_POINTS;
        return loop_count;
    endfunction

    // Divide by 2^(F+1) rounding halves up, then clamp to the coordinate range
    function automatic logic [C-1:0] round_sat(longint acc);
        longint r;
        r = (acc + (longint'(1) <<< F)) >>> (F + 1);
        if (r > COORD_MAX) r = COORD_MAX;
        else if (r < COORD_MIN) r = COORD_MIN;
        return r[C-1:0];
    endfunction

    // Position and tangent of the loop at global parameter gt, from the shadow table
    function automatic t_curve_pt curve_at(logic [F-1:0] gt);
        int unsigned n, seg, k;
        int unsigned tap [TAPS];
        longint      prod, t, t2, t3, one;
        longint      wp [TAPS];
        longint      wd [TAPS];
        longint      px, py, pz, dx, dy, dz;
        t_curve_pt   pt;
        n    = loop_points();
        one  = longint'(1) <<< F;
        prod = longint'(gt) * n;
        seg  = int'(prod >>> F);
        t    = prod & (one - 1);
        t2   = (t * t) >>> F;
        t3   = (t2 * t) >>> F;
        // taps seg-1 .. seg+2, wrapping around the loop
        tap[0] = (seg + n - 1) % n;
        for (k = 1; k < TAPS; k++) tap[k] = (tap[k-1] + 1) % n;
        // doubled basis weights in Q.F, and their derivative
        wp[0] = -t3 + 2 * t2 - t;
        wp[1] = 3 * t3 - 5 * t2 + 2 * one;
        wp[2] = -3 * t3 + 4 * t2 + t;
        wp[3] = t3 - t2;
        wd[0] = -3 * t2 + 4 * t - one;
        wd[1] = 9 * t2 - 10 * t;
        wd[2] = -9 * t2 + 8 * t + one;
        wd[3] = 3 * t2 - 2 * t;
        px = 0; py = 0; pz = 0; dx = 0; dy = 0; dz = 0;
        for (k = 0; k < TAPS; k++) begin
            px += wp[k] * knot_x[tap[k]];
            py += wp[k] * knot_y[tap[k]];
            pz += wp[k] * knot_z[tap[k]];
            dx += wd[k] * knot_x[tap[k]];
            dy += wd[k] * knot_y[tap[k]];
            dz += wd[k] * knot_z[tap[k]];
        end
        pt.pos_x = round_sat(px);
        pt.pos_y = round_sat(py);
        pt.pos_z = round_sat(pz);
        pt.tan_x = round_sat(dx);
        pt.tan_y = round_sat(dy);
        pt.tan_z = round_sat(dz);
        return pt;
    endfunction

    // Half extremes, zero and small values; the rest full-range
    function automatic logic [C-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(C-1){1'b1}}};
            1: return {1'b1, {(C-1){1'b0}}};
            2: return '0;
            3, 4: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_item(crl_pkg::t_kind kind, logic [IW-1:0] slot,
                                     logic [C-1:0] x, logic [C-1:0] y, logic [C-1:0] z,
                                     logic [F-1:0] gt, bit typed, t_curve_pt want);
        t_script_row row;
        row.op        = ROW_ITEM;
        row.item.kind = kind;
        row.item.slot = slot;
        row.item.x    = x;
        row.item.y    = y;
        row.item.z    = z;
        row.item.gt   = gt;
        row.count     = '0;
        row.typed     = typed;
        row.want      = want;
        script.insert(script.size(), row);
    endfunction

    function automatic void add_count(logic [CW-1:0] count);
        t_script_row row;
        row.op    = ROW_COUNT;
        row.item  = '{crl_pkg::KIND_LOAD, '0, '0, '0, '0, '0};
        row.count = count;
        row.typed = 1'b0;
        row.want  = '0;
        script.insert(script.size(), row);
    endfunction

    // Offer one item, wait for the handshake, then update the shadow or queue the result.
    // Called at a rising edge; returns at the edge that accepted the item.
    task automatic put_item(t_knot_item it, bit typed, t_curve_pt want, bit no_gap);
        int unsigned gap;
        t_curve_pt   owed;
        gap = (!no_gap && $urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= it.kind;
        i_point_index <= it.slot;
        i_point_x     <= it.x;
        i_point_y     <= it.y;
        i_point_z     <= it.z;
        i_global_t    <= it.gt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (it.kind == crl_pkg::KIND_LOAD) begin
            knot_x[it.slot] = longint'($signed(it.x));
            knot_y[it.slot] = longint'($signed(it.y));
            knot_z[it.slot] = longint'($signed(it.z));
            knot_loaded[it.slot] = 1'b1;
        end else begin
            owed = typed ? want : curve_at(it.gt);
            pending_pts.insert(pending_pts.size(), owed);
        end
    endtask

    // Stop offering, let every owed result come out, then let trailing loads settle
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_count(logic [CW-1:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        loop_count = count;
    endtask

    // Directed script. Slots 0..3 hold mostly extremes so that parameter values on a segment
    // start give results that are the point itself and half the neighbor difference.
    function automatic void build_script();
        add_item(crl_pkg::KIND_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                 '0, 1'b0, '0);
        add_item(crl_pkg::KIND_LOAD, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000,
                 '0, 1'b0, '0);
        add_item(crl_pkg::KIND_LOAD, 6'd2, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000,
                 '0, 1'b0, '0);
        add_item(crl_pkg::KIND_LOAD, 6'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0004_0000,
                 '0, 1'b0, '0);
        // reset count of 4, start of segment 0: tangent y saturates high
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h0000, 1'b1,
                 {32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                  32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_0000});
        // start of segment 1
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h4000, 1'b1,
                 {32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000,
                  32'hC000_0001, 32'h4000_0000, 32'h0001_0000});
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'hFFFF, 1'b0, '0);
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h2000, 1'b0, '0);  // mid-segment overshoot
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h0001, 1'b0, '0);
        add_item(crl_pkg::KIND_LOAD, 6'd63, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 '0, 1'b0, '0);
        add_count(7'd0);                                                    // acts as one point
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h8000, 1'b0, '0);
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'hFFFF, 1'b0, '0);
        add_count(7'd127);                                                  // clamps to table size
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h0000, 1'b0, '0);  // taps 63,0,1,2
        add_count(7'd64);
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h0400, 1'b0, '0);  // taps 0..3
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h0200, 1'b0, '0);  // taps 63,0,1,2
        add_count(7'd2);                                                    // taps wrap twice
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'hC000, 1'b0, '0);
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h7FFF, 1'b0, '0);
        add_count(7'd1);
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h5555, 1'b0, '0);
        add_count(7'd4);
        add_item(crl_pkg::KIND_EVAL, '0, '0, '0, '0, 16'h1234, 1'b0, '0);
    endfunction

    // Sender: reset, directed script, then random phases each under a fresh count
    initial begin : stimulus
        int            r, s;
        int unsigned   sent, len, n;
        bit            quiet;
        t_knot_item    it;
        logic [CW-1:0] count;
        build_script();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < script.size(); r++) begin
            if (script[r].op == ROW_COUNT) begin
                drain_pipe();
                program_count(script[r].count);
            end else begin
                put_item(script[r].item, script[r].typed, script[r].want, 1'b0);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:          count = '0;
                1:          count = 7'd127;
                2:          count = $urandom_range(MAX_POINTS + 1, 126);
                3:          count = MAX_POINTS;
                4, 5, 6, 7: count = $urandom_range(1, 3);
                8, 9:       count = $urandom_range(17, MAX_POINTS - 1);
                default:    count = $urandom_range(4, 16);
            endcase
            drain_pipe();
            program_count(count);
            len = $urandom_range(60, 200);
            while (len != 0 && sent < RANDOM_ITEMS) begin
                n       = loop_points();
                it.kind = crl_pkg::KIND_EVAL;
                it.slot = $urandom_range(0, MAX_POINTS - 1);
                it.x    = rand_coord();
                it.y    = rand_coord();
                it.z    = rand_coord();
                case ($urandom_range(0, 9))
                    0:       it.gt = '0;
                    1:       it.gt = '1;
                    default: it.gt = $urandom_range(0, 16'hFFFF);
                endcase
                // an evaluate may only touch loaded slots: fill the lowest hole first
                for (s = int'(n) - 1; s >= 0; s--) begin
                    if (!knot_loaded[s]) begin
                        it.kind = crl_pkg::KIND_LOAD;
                        it.slot = s;
                    end
                end
                if (it.kind == crl_pkg::KIND_EVAL && $urandom_range(0, 99) < 20) begin
                    it.kind = crl_pkg::KIND_LOAD;
                end
                quiet = (sent >= CALM_FROM && sent < CALM_TO);
                calm <= quiet;
                if (sent == SQUEEZE_AT) squeeze_req <= 1'b1;
                put_item(it, 1'b0, '0, quiet);
                sent++;
                len--;
            end
        end

        drain_pipe();
        if (mismatches == 0) begin
            $display("catmull_rom_loop_point_tb OK");
        end else begin
            $display("catmull_rom_loop_point_tb NOT OK");
        end
        $finish;
    end

    // Receiver: random back-pressure, none while calm, and one long hold-off that
    // fills the pipe so o_ready must drop while items keep being offered
    initial begin : result_sink
        int  hold_left;
        bit  squeezed;
        hold_left = 0;
        squeezed  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze_req && !squeezed) begin
                squeezed  = 1'b1;
                hold_left = SQUEEZE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (calm) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Every accepted result is matched field by field against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_curve_pt got, want;
        int        k;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_pos_x, o_pos_y, o_pos_z, o_tangent_x, o_tangent_y, o_tangent_z};
            if (pending_pts.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, pos_x %h", o_pos_x));
            end else begin
                want = pending_pts.pop_front();
                for (k = 0; k < 6; k++) begin
                    if (got[(5-k)*C +: C] !== want[(5-k)*C +: C]) begin
                        report_mismatch($sformatf("%s: expected %h, got %h", field_name[k],
                                                  want[(5-k)*C +: C], got[(5-k)*C +: C]));
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake on any channel ends the run
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("catmull_rom_loop_point_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/crl_pkg.sv
rtl/crl_ram.sv
rtl/crl_front.sv
rtl/crl_blend.sv
rtl/catmull_rom_loop_point.sv
rtl/crl_checker.sv
test/catmull_rom_loop_point_tb.sv
